// ===== rtl/sed_pkg.sv =====
// Shared types and constants for the speech end detector.
// No dependencies; imported by every module of the block.
package sed_pkg;

    // Input word: one audio sample plus its side flags.
    typedef struct packed {
        logic signed [15:0] sample;
        logic               last_in_block;
        logic               engine_idle;
        logic               engine_stalled;
        logic               restart;
    } t_in_item;

    // Result word: block decision and detector status.
    typedef struct packed {
        logic       block_is_speech;
        logic       speech_heard;
        logic       finished;
        logic [2:0] finish_reason;
    } t_out_item;

    // Kinds of event passed from the front end to the back end.
    typedef enum logic [1:0] {
        EV_RESTART = 2'd0,
        EV_STALL   = 2'd1,
        EV_BLOCK   = 2'd2
    } t_event_kind;

    typedef struct packed {
        t_event_kind kind;
        logic        speech;
        logic        idle;
    } t_queue_entry;

    // Limits used by the back end.
    typedef struct packed {
        logic [7:0] give_up_blocks;
        logic [7:0] silence_blocks_needed;
        logic [7:0] max_blocks;
    } t_back_cfg;

    // Finish reasons.
    localparam logic [2:0] REASON_RUNNING = 3'd0;
    localparam logic [2:0] REASON_GAVE_UP = 3'd1;
    localparam logic [2:0] REASON_SILENCE = 3'd2;
    localparam logic [2:0] REASON_CEILING = 3'd3;
    localparam logic [2:0] REASON_STALLED = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_SILENCE_THRESHOLD     = 2'd0;
    localparam logic [1:0] CFG_GIVE_UP_BLOCKS        = 2'd1;
    localparam logic [1:0] CFG_SILENCE_BLOCKS_NEEDED = 2'd2;
    localparam logic [1:0] CFG_MAX_BLOCKS            = 2'd3;

    // Configuration reset values.
    localparam logic [15:0] RST_SILENCE_THRESHOLD     = 16'd120;
    localparam logic [7:0]  RST_GIVE_UP_BLOCKS        = 8'd30;
    localparam logic [7:0]  RST_SILENCE_BLOCKS_NEEDED = 8'd4;
    localparam logic [7:0]  RST_MAX_BLOCKS            = 8'd125;

    localparam logic [7:0]  COUNT_MAX = 8'd255;

endpackage

// ===== rtl/sed_front.sv =====
// Front end: gathers per-block peak and flatness, classifies each closed block, passes on restarts and stalls.
// Depends on sed_pkg.
module sed_front
    import sed_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  t_in_item     i_item,
    input  logic [15:0]  i_threshold,
    output logic         o_push,
    output t_queue_entry o_entry
);

    logic [16:0] r_peak, n_peak;
    logic [15:0] r_first, n_first;
    logic        r_awaiting, n_awaiting;
    logic        r_flat, n_flat;

    logic signed [16:0] s_ext;
    logic [16:0]        mag;
    logic [16:0]        peak_acc;
    logic               flat_acc;

    always_comb begin
        s_ext    = 17'(i_item.sample);
        mag      = s_ext[16] ? 17'(-s_ext) : 17'(s_ext);
        peak_acc = (mag > r_peak) ? mag : r_peak;
        flat_acc = r_flat;
        if (!r_awaiting && (i_item.sample != r_first)) begin
            flat_acc = 1'b0;
        end

        n_peak     = r_peak;
        n_first    = r_first;
        n_awaiting = r_awaiting;
        n_flat     = r_flat;
        o_push     = 1'b0;
        o_entry    = '{kind: EV_BLOCK, speech: 1'b0, idle: i_item.engine_idle};

        if (i_accept) begin
            if (i_item.restart || i_item.engine_stalled || i_item.last_in_block) begin
                // Any of these closes or discards the block being gathered.
                n_peak     = '0;
                n_first    = '0;
                n_awaiting = 1'b1;
                n_flat     = 1'b1;
                o_push     = 1'b1;
                if (i_item.restart) begin
                    o_entry.kind = EV_RESTART;
                end else if (i_item.engine_stalled) begin
                    o_entry.kind = EV_STALL;
                end else begin
                    o_entry.speech = (peak_acc >= {1'b0, i_threshold}) && !flat_acc;
                end
            end else begin
                n_peak     = peak_acc;
                n_flat     = flat_acc;
                n_awaiting = 1'b0;
                if (r_awaiting) begin
                    n_first = i_item.sample;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_peak     <= '0;
            r_first    <= '0;
            r_awaiting <= 1'b1;
            r_flat     <= 1'b1;
        end else begin
            r_peak     <= n_peak;
            r_first    <= n_first;
            r_awaiting <= n_awaiting;
            r_flat     <= n_flat;
        end
    end

endmodule

// ===== rtl/sed_queue.sv =====
// Short event queue between the front end and the back end.
// Depends on sed_pkg.
module sed_queue
    import sed_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  t_queue_entry i_entry,
    output logic         o_space,
    output logic         o_valid,
    input  logic         i_pop,
    output t_queue_entry o_entry
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_queue_entry  r_mem [DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_space = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd];
    assign do_push = i_push && o_space;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/sed_back.sv =====
// Back end: two-phase end detection counters and the registered result word.
// Depends on sed_pkg.
module sed_back
    import sed_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_back_cfg    i_cfg,
    input  logic         i_q_valid,
    input  t_queue_entry i_q_entry,
    output logic         o_pop,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output t_out_item    o_out
);

    logic       r_heard, n_heard;
    logic [7:0] r_quiet, n_quiet;
    logic [7:0] r_lead, n_lead;
    logic [7:0] r_blocks, n_blocks;
    logic       r_done, n_done;
    logic [2:0] r_reason, n_reason;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;

    logic       emit;
    logic       speech_bit;
    logic [7:0] lead_inc, quiet_inc, blocks_inc;

    function automatic logic [7:0] sat_inc(input logic [7:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + 8'd1;
    endfunction

    assign o_pop       = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        lead_inc   = sat_inc(r_lead);
        quiet_inc  = sat_inc(r_quiet);
        blocks_inc = sat_inc(r_blocks);

        n_heard    = r_heard;
        n_quiet    = r_quiet;
        n_lead     = r_lead;
        n_blocks   = r_blocks;
        n_done     = r_done;
        n_reason   = r_reason;
        emit       = 1'b0;
        speech_bit = 1'b0;

        if (o_pop) begin
            case (i_q_entry.kind)
                EV_RESTART: begin
                    n_heard  = 1'b0;
                    n_quiet  = '0;
                    n_lead   = '0;
                    n_blocks = '0;
                    n_done   = 1'b0;
                    n_reason = REASON_RUNNING;
                end
                EV_STALL: begin
                    emit = 1'b1;
                    if (!r_done) begin
                        n_done   = 1'b1;
                        n_reason = REASON_STALLED;
                    end
                end
                EV_BLOCK: begin
                    emit = 1'b1;
                    // Once finished, a block end only reports the held status.
                    if (!r_done) begin
                        speech_bit = i_q_entry.speech;
                        if (i_q_entry.speech) begin
                            n_heard = 1'b1;
                            n_quiet = '0;
                        end else if (!r_heard) begin
                            n_lead = lead_inc;
                            if ((lead_inc >= i_cfg.give_up_blocks) && i_q_entry.idle) begin
                                n_done   = 1'b1;
                                n_reason = REASON_GAVE_UP;
                            end
                        end else if (i_q_entry.idle) begin
                            n_quiet = quiet_inc;
                            if (quiet_inc >= i_cfg.silence_blocks_needed) begin
                                n_done   = 1'b1;
                                n_reason = REASON_SILENCE;
                            end
                        end else begin
                            n_quiet = '0;
                        end

                        if (!n_done) begin
                            n_blocks = blocks_inc;
                            if (blocks_inc >= i_cfg.max_blocks) begin
                                n_done   = 1'b1;
                                n_reason = REASON_CEILING;
                            end
                        end
                    end
                end
                default: begin
                    emit = 1'b0;
                end
            endcase
        end

        n_out = r_out;
        if (emit) begin
            n_out.block_is_speech = speech_bit;
            n_out.speech_heard    = n_heard;
            n_out.finished        = n_done;
            n_out.finish_reason   = n_reason;
        end

        if (emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heard     <= 1'b0;
            r_quiet     <= '0;
            r_lead      <= '0;
            r_blocks    <= '0;
            r_done      <= 1'b0;
            r_reason    <= REASON_RUNNING;
            r_out_valid <= 1'b0;
        end else begin
            r_heard     <= n_heard;
            r_quiet     <= n_quiet;
            r_lead      <= n_lead;
            r_blocks    <= n_blocks;
            r_done      <= n_done;
            r_reason    <= n_reason;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== rtl/speech_end_detector.sv =====
// Speech end detector, top level: configuration registers, front end, queue, back end.
// A word that closes a block or stalls is queued, then registered in the result word.
// Throughput: one word per cycle unless the queue fills while the output is held back.
// Reset: synchronous, active low; clears configuration to defaults and all detector state.
// Depends on sed_pkg, sed_front, sed_queue and sed_back.
module speech_end_detector
    import sed_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    logic [15:0]  r_threshold;
    t_back_cfg    r_back_cfg;
    logic         in_accept;
    logic         push;
    t_queue_entry push_entry;
    logic         q_valid;
    logic         pop;
    t_queue_entry q_entry;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold                      <= RST_SILENCE_THRESHOLD;
            r_back_cfg.give_up_blocks        <= RST_GIVE_UP_BLOCKS;
            r_back_cfg.silence_blocks_needed <= RST_SILENCE_BLOCKS_NEEDED;
            r_back_cfg.max_blocks            <= RST_MAX_BLOCKS;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SILENCE_THRESHOLD:     r_threshold <= i_cfg_data;
                CFG_GIVE_UP_BLOCKS:        r_back_cfg.give_up_blocks <= i_cfg_data[7:0];
                CFG_SILENCE_BLOCKS_NEEDED: r_back_cfg.silence_blocks_needed <= i_cfg_data[7:0];
                CFG_MAX_BLOCKS:            r_back_cfg.max_blocks <= i_cfg_data[7:0];
                default:                   r_threshold <= r_threshold;
            endcase
        end
    end

    sed_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_item      (i_in),
        .i_threshold (r_threshold),
        .o_push      (push),
        .o_entry     (push_entry)
    );

    sed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (push_entry),
        .o_space (o_in_ready),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_entry (q_entry)
    );

    sed_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_back_cfg),
        .i_q_valid   (q_valid),
        .i_q_entry   (q_entry),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // A finished status always carries a reason, and a running one never does.
    a_reason_matches_finished: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.finished == (o_out.finish_reason != REASON_RUNNING)))
        else $error("finish reason disagrees with finished flag");

    // A speech block must be reported together with speech heard.
    a_speech_implies_heard: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.block_is_speech) |-> o_out.speech_heard)
        else $error("speech block reported without speech heard");

    // A word that the front end passes on must be waiting in the queue in the next cycle.
    a_event_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && push) |=> q_valid)
        else $error("accepted event missing from queue");

    // Only reasons that exist are ever reported.
    a_reason_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.finish_reason == REASON_RUNNING ||
                         o_out.finish_reason == REASON_GAVE_UP ||
                         o_out.finish_reason == REASON_SILENCE ||
                         o_out.finish_reason == REASON_CEILING ||
                         o_out.finish_reason == REASON_STALLED))
        else $error("unknown finish reason");

endmodule
